// ----- hdl/epaper_spi_frame_serializer_macros.svh -----
// Assertion macros used by the serializer top level.
`ifndef EPAPER_SPI_FRAME_SERIALIZER_MACROS_SVH
`define EPAPER_SPI_FRAME_SERIALIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ESFS_NEVER(label, clk_sig, rstn_sig, expr, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) !(expr)) \
        else $error(msg);

`define ESFS_IMPLIES(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

`define ESFS_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ESFS_NEVER(label, clk_sig, rstn_sig, expr, msg)

`define ESFS_IMPLIES(label, clk_sig, rstn_sig, ante, cons, msg)

`define ESFS_NEXT(label, clk_sig, rstn_sig, ante, cons, msg)

`endif

`endif

// ----- hdl/esfs_pkg.sv -----
// Types, constants and functions of the display serializer.
`default_nettype none

package esfs_pkg;

    localparam int ROW_PITCH_DEFAULT   = 22;
    localparam int LEFT_PAD_DEFAULT    = 1;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int COL_W   = 5;
    localparam int LEAD_W  = 3;
    localparam int TRAIL_W = 5;

    localparam logic [COL_W-1:0]  ROW_WIDTH_RESET = 5'd21;
    localparam logic [BYTE_W-1:0] PAD_WIRE        = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_COMMAND = 2'd0,
        CMD_DATA    = 2'd1,
        CMD_IMAGE   = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [LEAD_W-1:0]  lead;
        logic [BYTE_W-1:0]  body;
        logic               dc;
        logic [TRAIL_W-1:0] trail;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [BYTE_W-1:0] image_wire(input logic [BYTE_W-1:0] d);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++)
        begin
            r[i] = d[BYTE_W-1-i];
        end
        return ~r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/esfs_if.sv -----
// Stream interfaces for command items and wire bytes.
`default_nettype none

interface esfs_in_if
    import esfs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] value;

    modport source (output valid, cmd, value, input ready);
    modport sink   (input valid, cmd, value, output ready);
endinterface

interface esfs_out_if
    import esfs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] wire_byte;
    logic              dc_level;
    logic              run_last;

    modport source (output valid, wire_byte, dc_level, run_last, input ready);
    modport sink   (input valid, wire_byte, dc_level, run_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/esfs_front.sv -----
// Front end: accepts items, tracks the row column and builds byte jobs.
`default_nettype none

module esfs_front
    import esfs_pkg::*;
#(
    parameter int ROW_PITCH = ROW_PITCH_DEFAULT,
    parameter int LEFT_PAD  = LEFT_PAD_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [COL_W-1:0] cfg_wdata,
    esfs_in_if.sink               cmd_stream,
    input  wire q_stat_t          q_stat,
    output logic                  push,
    output job_t                  push_job
);

    localparam int LIM  = (ROW_PITCH > LEFT_PAD) ? (ROW_PITCH - LEFT_PAD) : 1;
    localparam int SPAN = ROW_PITCH - LEFT_PAD;

    localparam logic [COL_W:0]        LIM_W  = (COL_W+1)'(LIM);
    localparam logic signed [COL_W+1:0] SPAN_S = (COL_W+2)'(SPAN);

    logic [COL_W-1:0] row_width_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;

    logic [COL_W:0]            width_eff;
    logic signed [COL_W+1:0]   trail_diff;
    logic [TRAIL_W-1:0]        trail_cnt;
    logic                      row_end;
    logic                      accept;

    always_comb
    begin
        width_eff = (row_width_reg == '0) ? (COL_W+1)'(1) : {1'b0, row_width_reg};
        if (width_eff > LIM_W)
        begin
            width_eff = LIM_W;
        end
        trail_diff = SPAN_S - $signed({1'b0, width_eff});
        trail_cnt  = (trail_diff > 0) ? trail_diff[TRAIL_W-1:0] : '0;
        row_end    = (({1'b0, col_reg} + (COL_W+1)'(1)) >= width_eff);
    end

    assign cmd_stream.ready = !q_stat.full;
    assign accept           = cmd_stream.valid && cmd_stream.ready;

    always_comb
    begin
        push           = 1'b0;
        col_next       = col_reg;
        push_job.lead  = '0;
        push_job.body  = cmd_stream.value;
        push_job.dc    = 1'b1;
        push_job.trail = '0;
        case (cmd_stream.cmd)
            CMD_COMMAND:
            begin
                push        = accept;
                push_job.dc = 1'b0;
                col_next    = '0;
            end
            CMD_DATA:
            begin
                push = accept;
            end
            CMD_IMAGE:
            begin
                push          = accept;
                push_job.body = image_wire(cmd_stream.value);
                push_job.lead = (col_reg == '0) ? LEAD_W'(LEFT_PAD) : '0;
                if (row_end)
                begin
                    push_job.trail = trail_cnt;
                    col_next       = '0;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            col_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                row_width_reg <= cfg_wdata;
            end
            if (accept)
            begin
                col_reg <= col_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/esfs_queue.sv -----
// Job queue between the front end and the byte sequencer.
`default_nettype none

module esfs_queue
    import esfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head_job,
    output q_stat_t   q_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    job_t mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign head_job     = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/esfs_back.sv -----
// Back end: expands jobs into pad and payload bytes behind an output register.
`default_nettype none

module esfs_back
    import esfs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire job_t    head_job,
    input  wire q_stat_t q_stat,
    output logic         pop,
    esfs_out_if.source   wire_stream
);

    logic               active_reg;
    logic               active_next;
    logic [LEAD_W-1:0]  lead_reg;
    logic [LEAD_W-1:0]  lead_next;
    logic               body_pend_reg;
    logic               body_pend_next;
    logic [TRAIL_W-1:0] trail_reg;
    logic [TRAIL_W-1:0] trail_next;
    logic [BYTE_W-1:0]  body_reg;
    logic [BYTE_W-1:0]  body_next;
    logic               dc_reg;
    logic               dc_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [BYTE_W-1:0]  out_byte_next;
    logic               out_dc_reg;
    logic               out_dc_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic               src_body_pend;
    job_t               src;
    logic               slot_free;
    logic               advance;
    logic               rem_any;

    assign wire_stream.valid     = out_valid_reg;
    assign wire_stream.wire_byte = out_byte_reg;
    assign wire_stream.dc_level  = out_dc_reg;
    assign wire_stream.run_last  = out_last_reg;

    always_comb
    begin
        if (active_reg)
        begin
            src.lead      = lead_reg;
            src.body      = body_reg;
            src.dc        = dc_reg;
            src.trail     = trail_reg;
            src_body_pend = body_pend_reg;
        end
        else
        begin
            src           = head_job;
            src_body_pend = 1'b1;
        end

        slot_free = !out_valid_reg || wire_stream.ready;
        advance   = slot_free && (active_reg || !q_stat.empty);
        pop       = advance && !active_reg;

        lead_next      = src.lead;
        body_pend_next = src_body_pend;
        trail_next     = src.trail;
        body_next      = src.body;
        dc_next        = src.dc;
        out_byte_next  = PAD_WIRE;

        if (src.lead != '0)
        begin
            lead_next = src.lead - LEAD_W'(1);
        end
        else if (src_body_pend)
        begin
            body_pend_next = 1'b0;
            out_byte_next  = src.body;
        end
        else
        begin
            trail_next = src.trail - TRAIL_W'(1);
        end

        rem_any       = (lead_next != '0) || body_pend_next || (trail_next != '0);
        out_dc_next   = src.dc;
        out_last_next = !rem_any;

        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        if (slot_free)
        begin
            out_valid_next = advance;
        end
        if (advance)
        begin
            active_next = rem_any;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lead_reg      <= lead_next;
            body_pend_reg <= body_pend_next;
            trail_reg     <= trail_next;
            body_reg      <= body_next;
            dc_reg        <= dc_next;
            out_byte_reg  <= out_byte_next;
            out_dc_reg    <= out_dc_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/epaper_spi_frame_serializer.sv -----
// Top level of the display serializer with data/command line.
// Usage:
//   cmd_stream carries one software item per transfer: cmd selects a command
//   byte, a plain data byte or an image byte; the fourth code is dropped.
//   wire_stream carries one byte per transfer: the data
//   pin levels in send order, the data/command level and a flag on the last
//   byte that an item produced.
//   cfg_we/cfg_wdata write the row width; write it only while the block idles.
// Timing:
//   The front end takes an item in every cycle while the job queue has room.
//   The back end sends one wire byte per cycle from the queue head while the
//   receiver is ready; an image item at the start or the end of a row adds
//   pad bytes (LEFT_PAD before, ROW_PITCH - LEFT_PAD - width after) to its
//   image byte. Each job passes through the queue and the output register.
// Reset:
//   Clears the queue, the column count and the output register; the row
//   width returns to 21.
// Stall:
//   A stalled receiver holds the output register; the queue fills and then
//   cmd_stream.ready drops.
`default_nettype none

`include "epaper_spi_frame_serializer_macros.svh"

module epaper_spi_frame_serializer
    import esfs_pkg::*;
#(
    parameter int ROW_PITCH   = ROW_PITCH_DEFAULT,
    parameter int LEFT_PAD    = LEFT_PAD_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [COL_W-1:0] cfg_wdata,
    esfs_in_if.sink               cmd_stream,
    esfs_out_if.source            wire_stream
);

    logic    push;
    logic    pop;
    job_t    push_job;
    job_t    head_job;
    q_stat_t q_stat;

    esfs_front #(
        .ROW_PITCH (ROW_PITCH),
        .LEFT_PAD  (LEFT_PAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd_stream (cmd_stream),
        .q_stat     (q_stat),
        .push       (push),
        .push_job   (push_job)
    );

    esfs_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_stat   (q_stat)
    );

    esfs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_job    (head_job),
        .q_stat      (q_stat),
        .pop         (pop),
        .wire_stream (wire_stream)
    );

    `ESFS_NEVER(a_no_overflow, clk, rst_n, push && q_stat.full && !pop, "queue overflow")
    `ESFS_NEVER(a_no_underflow, clk, rst_n, pop && q_stat.empty, "queue underflow")
    `ESFS_IMPLIES(a_cmd_single, clk, rst_n, wire_stream.valid && !wire_stream.dc_level, wire_stream.run_last, "command byte not last")
    `ESFS_NEXT(a_out_hold, clk, rst_n, wire_stream.valid && !wire_stream.ready, wire_stream.valid && $stable(wire_stream.wire_byte), "output changed while stalled")

endmodule

`default_nettype wire

// ----- sim/epaper_spi_frame_serializer_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts each wire byte of the display serializer and compares it.
module epaper_spi_frame_serializer_checker
    import esfs_pkg::*;
#(
    parameter int ROW_PITCH = ROW_PITCH_DEFAULT,
    parameter int LEFT_PAD  = LEFT_PAD_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [COL_W-1:0] cfg_wdata,
    esfs_in_if               cmd_mon,
    esfs_out_if              wire_mon,
    output int               mismatches,
    output int               pending,
    output int               checked
);

    typedef struct packed {
        logic [BYTE_W-1:0] wire_byte;
        logic              dc_level;
        logic              run_last;
    } wire_beat_t;

    wire_beat_t       expected_beats[$];
    logic [COL_W-1:0] row_width;
    logic [COL_W-1:0] column;

    task automatic queue_beat(input logic [BYTE_W-1:0] b, input logic dc, input logic last);
        wire_beat_t beat;
        beat.wire_byte = b;
        beat.dc_level  = dc;
        beat.run_last  = last;
        expected_beats.push_back(beat);
    endtask

    task automatic predict_item(input cmd_t c, input logic [BYTE_W-1:0] v);
        int                limit;
        int                width;
        int                trail;
        logic              row_end;
        logic [BYTE_W-1:0] flipped;
        limit = (ROW_PITCH > LEFT_PAD) ? ROW_PITCH - LEFT_PAD : 1;
        width = int'(row_width);
        if (width == 0)
            width = 1;
        if (width > limit)
            width = limit;
        trail = ROW_PITCH - LEFT_PAD - width;
        if (trail < 0)
            trail = 0;
        case (c)
            CMD_COMMAND:
            begin
                column = '0;
                queue_beat(v, 1'b0, 1'b1);
            end
            CMD_DATA:
            begin
                queue_beat(v, 1'b1, 1'b1);
            end
            CMD_IMAGE:
            begin
                row_end = (int'(column) + 1) >= width;
                flipped = {<<{v}};
                if (column == '0)
                begin
                    for (int i = 0; i < LEFT_PAD; i++)
                        queue_beat(PAD_WIRE, 1'b1, 1'b0);
                end
                queue_beat(~flipped, 1'b1, !(row_end && trail > 0));
                if (row_end)
                begin
                    for (int i = 0; i < trail; i++)
                        queue_beat(PAD_WIRE, 1'b1, i == trail - 1);
                    column = '0;
                end
                else
                begin
                    column = column + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_beat();
        wire_beat_t want;
        if (expected_beats.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected wire byte %02h dc %0b last %0b with nothing pending",
                         wire_mon.wire_byte, wire_mon.dc_level, wire_mon.run_last);
        end
        else
        begin
            want = expected_beats.pop_front();
            if (want.wire_byte !== wire_mon.wire_byte || want.dc_level !== wire_mon.dc_level
                || want.run_last !== wire_mon.run_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("byte %0d: expected wire %02h dc %0b last %0b, got wire %02h dc %0b last %0b",
                             checked, want.wire_byte, want.dc_level, want.run_last,
                             wire_mon.wire_byte, wire_mon.dc_level, wire_mon.run_last);
            end
        end
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width  = ROW_WIDTH_RESET;
            column     = '0;
            mismatches = 0;
            checked    = 0;
            expected_beats.delete();
        end
        else
        begin
            if (wire_mon.valid && wire_mon.ready)
                check_beat();
            if (cmd_mon.valid && cmd_mon.ready)
                predict_item(cmd_t'(cmd_mon.cmd), cmd_mon.value);
            if (cfg_we)
                row_width = cfg_wdata;
        end
        pending = expected_beats.size();
    end

endmodule

// ----- sim/epaper_spi_frame_serializer_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: drives command items and row widths into the serializer and gives the verdict.
module epaper_spi_frame_serializer_tb
    import esfs_pkg::*;
();

    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 17;
    localparam int PHASES          = 8;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [COL_W-1:0] cfg_wdata;

    int mismatches;
    int pending;
    int checked;
    int items_sent;
    int images_sent;
    int ignored_sent;
    int widths_used;
    int hold_offs;
    bit tx_quiet;
    bit hold_off_req;

    esfs_in_if  cmd_bus();
    esfs_out_if wire_bus();

    epaper_spi_frame_serializer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .cmd_stream  (cmd_bus),
        .wire_stream (wire_bus)
    );

    epaper_spi_frame_serializer_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd_mon    (cmd_bus),
        .wire_mon   (wire_bus),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input cmd_t c, input logic [BYTE_W-1:0] v);
        int gap;
        cmd_bus.valid <= 1'b1;
        cmd_bus.cmd   <= c;
        cmd_bus.value <= v;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        if (c == CMD_NONE)
            ignored_sent++;
        else
            items_sent++;
        if (c == CMD_IMAGE)
            images_sent++;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(input logic [COL_W-1:0] w);
        cmd_bus.valid <= 1'b0;
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        widths_used++;
    endtask

    task automatic send_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            send_item(CMD_COMMAND, 8'($urandom));
        else if (r < 16)
            send_item(CMD_DATA, 8'($urandom));
        else if (r < 20)
            send_item(CMD_NONE, 8'($urandom));
        else
            send_item(CMD_IMAGE, 8'($urandom));
    endtask

    task automatic ready_wait(input int cycles);
        for (int i = 0; i < cycles; i++)
        begin
            @(posedge clk);
            if (hold_off_req)
                break;
        end
    endtask

    initial
    begin
        int gap;
        wire_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_offs++;
                wire_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                wire_bus.ready <= 1'b1;
                if ($urandom_range(0, 9) == 0)
                    ready_wait($urandom_range(50, 150));
                else
                    ready_wait($urandom_range(1, 8));
                gap = pick_gap();
                if (gap > 0 && !hold_off_req)
                begin
                    wire_bus.ready <= 1'b0;
                    ready_wait(gap);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int               start;
        logic [COL_W-1:0] w;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        cmd_bus.valid <= 1'b0;
        cmd_bus.cmd   <= CMD_COMMAND;
        cmd_bus.value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(CMD_COMMAND, 8'h00);
        send_item(CMD_COMMAND, 8'hFF);
        send_item(CMD_DATA, 8'h00);
        send_item(CMD_DATA, 8'hFF);
        send_item(CMD_IMAGE, 8'h01);
        send_item(CMD_IMAGE, 8'h80);
        send_item(CMD_NONE, 8'h5A);
        send_item(CMD_IMAGE, 8'hFF);
        send_item(CMD_IMAGE, 8'h00);
        send_item(CMD_COMMAND, 8'hA5);
        send_item(CMD_IMAGE, 8'h0F);
        send_item(CMD_IMAGE, 8'hF0);
        send_item(CMD_IMAGE, 8'h3C);
        send_item(CMD_IMAGE, 8'hC3);
        send_item(CMD_IMAGE, 8'h55);
        set_width(5'd2);
        send_item(CMD_IMAGE, 8'hAA);
        send_item(CMD_IMAGE, 8'h12);
        set_width(5'd0);
        send_item(CMD_IMAGE, 8'h34);
        send_item(CMD_IMAGE, 8'h56);
        set_width(5'd31);
        send_item(CMD_IMAGE, 8'h78);
        send_item(CMD_DATA, 8'h9A);
        set_width(5'd1);
        send_item(CMD_IMAGE, 8'hBC);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: w = 5'd1;
                1: w = 5'd21;
                2: w = 5'd31;
                3: w = 5'd0;
                4: w = 5'd20;
                default: w = 5'($urandom_range(0, 31));
            endcase
            set_width(w);
            tx_quiet = (phase % 3 == 2);
            if (phase == 1)
                hold_off_req = 1'b1;
            start = items_sent;
            send_item(CMD_COMMAND, 8'($urandom));
            while (items_sent - start < PHASE_ITEMS)
                send_random_item();
        end

        cmd_bus.valid <= 1'b0;
        wait_idle();

        $display("run covered %0d items (%0d image, %0d ignored) across %0d row width settings",
                 items_sent, images_sent, ignored_sent, widths_used);
        $display("compared %0d wire bytes; receiver held off %0d times for %0d cycles",
                 checked, hold_offs, HOLD_OFF_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/esfs_pkg.sv
hdl/esfs_if.sv
hdl/esfs_front.sv
hdl/esfs_queue.sv
hdl/esfs_back.sv
hdl/epaper_spi_frame_serializer.sv
sim/epaper_spi_frame_serializer_checker.sv
sim/epaper_spi_frame_serializer_tb.sv
